/* design/ikc_pkg.sv */
// Shared constants and types for the image kernel convolution unit.
package ikc_pkg;

   localparam int KMAX          = 7;
   localparam int TAP_COUNT     = KMAX * KMAX;
   localparam int IMG_W_MAX     = 1024;
   localparam int IMG_H_MAX     = 4096;
   localparam int FRAC_BITS     = 12;
   localparam int ROW_SLOTS     = 8;
   localparam int HAZARD_ROWS   = ROW_SLOTS - KMAX / 2 - 1;
   localparam int QUEUE_DEPTH_D = 16;

   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_COEF  = 2'd1;

   localparam logic [3:0] CSR_IMAGE_WIDTH   = 4'd0;
   localparam logic [3:0] CSR_IMAGE_HEIGHT  = 4'd1;
   localparam logic [3:0] CSR_CHANNEL_COUNT = 4'd2;
   localparam logic [3:0] CSR_KERNEL_SIZE   = 4'd3;
   localparam logic [3:0] CSR_AREA_LEFT     = 4'd4;
   localparam logic [3:0] CSR_AREA_TOP      = 4'd5;
   localparam logic [3:0] CSR_AREA_RIGHT    = 4'd6;
   localparam logic [3:0] CSR_AREA_BOTTOM   = 4'd7;

   typedef logic [KMAX-1:0][31:0]    col_type;
   typedef logic [KMAX-1:0][17:0]    coef_col_type;
   typedef logic [3:0][28:0]         csum_type;
   typedef logic [ROW_SLOTS-1:0][31:0] bank_type;

   typedef struct packed {
      logic [9:0]  col;
      logic [11:0] row;
      logic        done;
   } job_type;

   typedef struct packed {
      logic [9:0]      col;
      logic [11:0]     row;
      logic [3:0][7:0] chan;
      logic            done;
   } rsp_type;

endpackage

/* design/ikc_fifo.sv */
// Small first-in first-out queue with show-ahead read data.
module ikc_fifo import ikc_pkg::*; #(
   parameter int WIDTH = $bits(job_type),
   parameter int DEPTH = QUEUE_DEPTH_D
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             nonempty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]      cnt_ff, cnt_in;

   always_comb begin
      wptr_in = push ? wptr_ff + AW'(1) : wptr_ff;
      rptr_in = pop ? rptr_ff + AW'(1) : rptr_ff;
      cnt_in  = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rptr_ff];
   assign nonempty = (cnt_ff != '0);

endmodule

/* design/ikc_rows.sv */
// Circular row store: one memory bank per row slot, all read at one column.
module ikc_rows import ikc_pkg::*; (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(ROW_SLOTS)-1:0] wr_slot,
   input  logic [$clog2(IMG_W_MAX)-1:0] wr_col,
   input  logic [31:0]                  wr_data,
   input  logic [$clog2(IMG_W_MAX)-1:0] rd_col,
   output bank_type                     rd_data
);

   for (genvar b = 0; b < ROW_SLOTS; b++) begin : g_bank
      logic [31:0] mem [IMG_W_MAX];
      logic [31:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_slot == ($clog2(ROW_SLOTS))'(b))) begin
            mem[wr_col] <= wr_data;
         end
         q_ff <= mem[rd_col];
      end

      assign rd_data[b] = q_ff;
   end

endmodule

/* design/ikc_cell.sv */
// One window column cell: holds a pixel column, multiplies and sums it per channel.
module ikc_cell import ikc_pkg::*; (
   input  logic                clock,
   input  logic                shift_en,
   input  col_type             col_in,
   input  coef_col_type        coef_in,
   input  logic [KMAX-1:0]     tap_en,
   output col_type             col_out,
   output csum_type            sum_out
);

   col_type  col_ff;
   logic signed [25:0] prod_ff [KMAX][4];
   logic signed [25:0] prod_in [KMAX][4];
   csum_type sum_ff, sum_in;

   always_comb begin
      logic signed [28:0] acc;
      for (int r = 0; r < KMAX; r++) begin
         for (int ch = 0; ch < 4; ch++) begin
            prod_in[r][ch] = tap_en[r]
               ? 26'($signed(coef_in[r]) * $signed({1'b0, col_ff[r][8*ch +: 8]}))
               : 26'sd0;
         end
      end
      for (int ch = 0; ch < 4; ch++) begin
         acc = '0;
         for (int r = 0; r < KMAX; r++) begin
            acc = acc + 29'(prod_ff[r][ch]);
         end
         sum_in[ch] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign col_out = col_ff;
   assign sum_out = sum_ff;

endmodule

/* design/image_kernel_convolution_unit.sv */
// Streaming 2D convolution: at most one output pixel per accepted item.
// One item is accepted per cycle while req_ready is high. A sliding window needs
// one new column read and a refilled window, at the start of an output run, needs kernel
// size reads, because the row store gives one pixel column per cycle.
// Items are not taken while the frame restart that follows reset or a write to a defined register is pending.
// Reset restores register defaults, clears coefficients and restarts the frame.
module image_kernel_convolution_unit import ikc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_pix_c0,
   input  logic [7:0]         req_pix_c1,
   input  logic [7:0]         req_pix_c2,
   input  logic [7:0]         req_pix_c3,
   input  logic [5:0]         req_coef_index,
   input  logic signed [17:0] req_coef_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_out_col,
   output logic [11:0]        rsp_out_row,
   output logic [7:0]         rsp_out_c0,
   output logic [7:0]         rsp_out_c1,
   output logic [7:0]         rsp_out_c2,
   output logic [7:0]         rsp_out_c3,
   output logic               rsp_area_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [12:0]        csr_wdata
);

   localparam int QW = $clog2(QUEUE_DEPTH) + 1;

   logic [10:0] cfg_width_ff, cfg_width_in, cfg_left_ff, cfg_left_in, cfg_right_ff, cfg_right_in;
   logic [12:0] cfg_height_ff, cfg_height_in, cfg_top_ff, cfg_top_in;
   logic [12:0] cfg_bottom_ff, cfg_bottom_in;
   logic [2:0]  cfg_chan_ff, cfg_chan_in, cfg_ksize_ff, cfg_ksize_in;
   logic        restart_ff, restart_in, csr_hit;

   logic [10:0] eff_w, rgt;
   logic [12:0] eff_h, bot;
   logic [2:0]  nch, ksz;
   logic [1:0]  half, hi;
   logic        start_busy;

   logic [9:0]  in_col_ff, in_col_in;
   logic [12:0] in_row_ff, in_row_in;
   logic [10:0] ptr_x_ff, ptr_x_in;
   logic [12:0] ptr_y_ff, ptr_y_in;
   logic        busy_ff, busy_in;

   logic [17:0] coef_ff [TAP_COUNT];
   logic        req_acc, is_pix, is_coef, wrap;
   logic [9:0]  b_col, n_col;
   logic [12:0] b_row, n_row, rr;
   logic [10:0] b_px, cc;
   logic [12:0] b_py;
   logic        b_busy, emit, job_push;
   job_type     job_new, head;
   logic        job_ne, rd_busy, hazard;
   logic [11:0] oldest_y;
   logic [QW-1:0] outst_ff, outst_in;
   logic        rsp_acc;

   logic        fetch_act_ff, fetch_act_in, pop, contig, iss, iss_last;
   logic [2:0]  cnt_ff, cnt_in;
   logic signed [11:0] sx_ff, sx_in, iss_sx;
   job_type     cur_ff, cur_in, iss_job;
   logic        prev_vld_ff, prev_vld_in;
   logic [9:0]  prev_x_ff, prev_x_in;
   logic [11:0] prev_y_ff, prev_y_in;
   logic signed [13:0] sy_base;
   logic [KMAX-1:0] iss_mask;
   logic        iss_colok;

   logic        rd_vld_ff, rd_last_ff, rd_colok_ff;
   logic [KMAX-1:0] rd_mask_ff;
   logic [2:0]  rd_base_ff;
   job_type     rd_job_ff;
   bank_type    bank_q;
   col_type     new_col;

   logic        win_vld_ff, p_vld_ff, s_vld_ff;
   job_type     win_job_ff, p_job_ff, s_job_ff;

   col_type      cell_col [KMAX];
   csum_type     cell_sum [KMAX];
   coef_col_type cell_coef [KMAX];
   logic [KMAX-1:0] cell_en [KMAX];

   rsp_type     rsp_new, rsp_head;

   // Register port and derived frame geometry.
   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_chan_in   = cfg_chan_ff;
      cfg_ksize_in  = cfg_ksize_ff;
      cfg_left_in   = cfg_left_ff;
      cfg_top_in    = cfg_top_ff;
      cfg_right_in  = cfg_right_ff;
      cfg_bottom_in = cfg_bottom_ff;
      csr_hit       = 1'b0;
      if (csr_valid) begin
         csr_hit = 1'b1;
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_width_in  = csr_wdata[10:0];
            CSR_IMAGE_HEIGHT:  cfg_height_in = csr_wdata;
            CSR_CHANNEL_COUNT: cfg_chan_in   = csr_wdata[2:0];
            CSR_KERNEL_SIZE:   cfg_ksize_in  = csr_wdata[2:0];
            CSR_AREA_LEFT:     cfg_left_in   = csr_wdata[10:0];
            CSR_AREA_TOP:      cfg_top_in    = csr_wdata;
            CSR_AREA_RIGHT:    cfg_right_in  = csr_wdata[10:0];
            CSR_AREA_BOTTOM:   cfg_bottom_in = csr_wdata;
            default:           csr_hit       = 1'b0;
         endcase
      end
      restart_in = csr_hit;

      eff_w = (cfg_width_ff == '0) ? 11'd1 :
              (cfg_width_ff > 11'(IMG_W_MAX)) ? 11'(IMG_W_MAX) : cfg_width_ff;
      eff_h = (cfg_height_ff == '0) ? 13'd1 :
              (cfg_height_ff > 13'(IMG_H_MAX)) ? 13'(IMG_H_MAX) : cfg_height_ff;
      nch   = (cfg_chan_ff == '0) ? 3'd1 : (cfg_chan_ff > 3'd4) ? 3'd4 : cfg_chan_ff;
      ksz   = cfg_ksize_ff;
      half  = ksz[2:1];
      hi    = (ksz == '0) ? 2'd0 : 2'(ksz - 3'd1 - {1'b0, half});
      rgt   = (cfg_right_ff < eff_w) ? cfg_right_ff : eff_w;
      bot   = (cfg_bottom_ff < eff_h) ? cfg_bottom_ff : eff_h;
      start_busy = (cfg_left_ff < rgt) && (cfg_top_ff < bot);
   end

   assign csr_ready = 1'b1;

   // Input side: row store write, pointer walk and output decision.
   assign is_pix  = (req_operation == OP_PIXEL);
   assign is_coef = (req_operation == OP_COEF);
   assign rd_busy = job_ne || fetch_act_ff;
   assign oldest_y = fetch_act_ff ? cur_ff.row : head.row;
   assign hazard  = ({1'b0, in_row_ff} >= ({2'b0, oldest_y} + 14'(HAZARD_ROWS)));
   assign wrap    = is_pix && (in_row_ff >= eff_h);

   assign req_ready = !restart_ff && (outst_ff < QW'(QUEUE_DEPTH))
                    && !(is_coef && (rd_busy || rd_vld_ff || win_vld_ff))
                    && !(is_pix && rd_busy && (wrap || hazard));
   assign req_acc = req_valid && req_ready;

   always_comb begin
      logic [10:0] col_inc;
      logic [13:0] ry;
      logic [11:0] rx;
      logic [11:0] px1;
      logic [13:0] py1;

      b_col  = wrap ? 10'd0 : in_col_ff;
      b_row  = wrap ? 13'd0 : in_row_ff;
      b_px   = wrap ? cfg_left_ff : ptr_x_ff;
      b_py   = wrap ? cfg_top_ff : ptr_y_ff;
      b_busy = wrap ? start_busy : busy_ff;

      col_inc = {1'b0, b_col} + 11'd1;
      n_col = b_col;
      n_row = b_row;
      if (is_pix) begin
         if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = b_row + 13'd1;
         end else begin
            n_col = col_inc[9:0];
         end
      end

      ry = {1'b0, b_py} + 14'(hi);
      rr = (ry < 14'(eff_h - 13'd1)) ? ry[12:0] : eff_h - 13'd1;
      rx = {1'b0, b_px} + 12'(hi);
      cc = (rx < 12'(eff_w - 11'd1)) ? rx[10:0] : eff_w - 11'd1;
      emit = b_busy && ((n_row > rr) || ((n_row == rr) && ({1'b0, n_col} > cc)));

      job_new.col  = b_px[9:0];
      job_new.row  = b_py[11:0];
      job_new.done = (b_px == rgt - 11'd1) && (b_py == bot - 13'd1);
      job_push = req_acc && emit;

      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      ptr_x_in  = ptr_x_ff;
      ptr_y_in  = ptr_y_ff;
      busy_in   = busy_ff;
      px1 = {1'b0, b_px} + 12'd1;
      py1 = {1'b0, b_py} + 14'd1;
      if (restart_ff) begin
         in_col_in = '0;
         in_row_in = '0;
         ptr_x_in  = cfg_left_ff;
         ptr_y_in  = cfg_top_ff;
         busy_in   = start_busy;
      end else if (req_acc) begin
         in_col_in = n_col;
         in_row_in = n_row;
         ptr_x_in  = b_px;
         ptr_y_in  = b_py;
         busy_in   = b_busy;
         if (emit) begin
            if (px1 >= {1'b0, rgt}) begin
               ptr_x_in = cfg_left_ff;
               ptr_y_in = py1[12:0];
               if (py1 >= {1'b0, bot}) begin
                  busy_in = 1'b0;
               end
            end else begin
               ptr_x_in = px1[10:0];
            end
         end
      end

      rsp_acc  = rsp_valid && rsp_ready;
      outst_in = outst_ff + QW'(job_push) - QW'(rsp_acc);
   end

   ikc_rows u_rows (
      .clock   (clock),
      .wr_en   (req_acc && is_pix),
      .wr_slot (b_row[2:0]),
      .wr_col  (b_col),
      .wr_data ({req_pix_c3, req_pix_c2, req_pix_c1, req_pix_c0}),
      .rd_col  (iss_sx[9:0]),
      .rd_data (bank_q)
   );

   ikc_fifo #(.WIDTH($bits(job_type)), .DEPTH(QUEUE_DEPTH)) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_new),
      .pop       (pop),
      .pop_data  (head),
      .nonempty  (job_ne)
   );

   // Column fetch sequencer: one row store read per cycle.
   always_comb begin
      logic signed [13:0] sy;
      pop    = !fetch_act_ff && job_ne;
      contig = prev_vld_ff && (head.row == prev_y_ff) && (head.col == prev_x_ff + 10'd1);
      iss    = fetch_act_ff || pop;
      iss_job = fetch_act_ff ? cur_ff : head;
      if (fetch_act_ff) begin
         iss_sx   = sx_ff;
         iss_last = (cnt_ff == 3'd1);
      end else if (contig) begin
         iss_sx   = $signed({2'b0, head.col}) + $signed({10'b0, hi});
         iss_last = 1'b1;
      end else begin
         iss_sx   = $signed({2'b0, head.col}) - $signed({10'b0, half});
         iss_last = (ksz <= 3'd1);
      end
      iss_colok = !iss_sx[11] && (iss_sx[10:0] < eff_w);
      sy_base   = $signed({2'b0, iss_job.row}) - $signed({12'b0, half});
      for (int r = 0; r < KMAX; r++) begin
         sy = sy_base + 14'(r);
         iss_mask[r] = (r < int'(ksz)) && !sy[13] && (sy < $signed({1'b0, eff_h}));
      end

      fetch_act_in = fetch_act_ff;
      cnt_in       = cnt_ff;
      sx_in        = sx_ff;
      cur_in       = cur_ff;
      prev_vld_in  = prev_vld_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      if (fetch_act_ff) begin
         fetch_act_in = (cnt_ff != 3'd1);
         cnt_in       = cnt_ff - 3'd1;
         sx_in        = sx_ff + 12'sd1;
      end else if (pop) begin
         prev_vld_in = 1'b1;
         prev_x_in   = head.col;
         prev_y_in   = head.row;
         if (!iss_last) begin
            fetch_act_in = 1'b1;
            cnt_in       = ksz - 3'd1;
            sx_in        = iss_sx + 12'sd1;
            cur_in       = head;
         end
      end
      if (restart_ff || (req_acc && wrap)) begin
         prev_vld_in = 1'b0;
      end
   end

   always_comb begin
      for (int r = 0; r < KMAX; r++) begin
         new_col[r] = (rd_mask_ff[r] && rd_colok_ff) ? bank_q[3'(rd_base_ff + 3'(r))] : 32'd0;
      end
   end

   // Coefficients arranged by window cell and row.
   always_comb begin
      int xx;
      for (int c = 0; c < KMAX; c++) begin
         for (int r = 0; r < KMAX; r++) begin
            xx = c - (KMAX - int'(ksz));
            cell_en[c][r]   = (r < int'(ksz)) && (xx >= 0);
            cell_coef[c][r] = cell_en[c][r] ? coef_ff[6'(xx + r * int'(ksz))] : 18'd0;
         end
      end
   end

   for (genvar c = 0; c < KMAX; c++) begin : g_cell
      ikc_cell u_cell (
         .clock    (clock),
         .shift_en (rd_vld_ff),
         .col_in   ((c == KMAX - 1) ? new_col : cell_col[(c + 1) % KMAX]),
         .coef_in  (cell_coef[c]),
         .tap_en   (cell_en[c]),
         .col_out  (cell_col[c]),
         .sum_out  (cell_sum[c])
      );
   end

   // Channel totals, rounding and clamping.
   always_comb begin
      logic signed [32:0] tot;
      logic signed [32:0] q;
      for (int ch = 0; ch < 4; ch++) begin
         tot = 33'sd1 <<< (FRAC_BITS - 1);
         for (int c = 0; c < KMAX; c++) begin
            tot = tot + 33'($signed(cell_sum[c][ch]));
         end
         q = tot >>> FRAC_BITS;
         if ((ch >= int'(nch)) || (tot <= 33'sd0)) begin
            rsp_new.chan[ch] = 8'd0;
         end else if (q > 33'sd255) begin
            rsp_new.chan[ch] = 8'hff;
         end else begin
            rsp_new.chan[ch] = q[7:0];
         end
      end
      rsp_new.col  = s_job_ff.col;
      rsp_new.row  = s_job_ff.row;
      rsp_new.done = s_job_ff.done;
   end

   ikc_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s_vld_ff),
      .push_data (rsp_new),
      .pop       (rsp_acc),
      .pop_data  (rsp_head),
      .nonempty  (rsp_valid)
   );

   assign rsp_out_col   = rsp_head.col;
   assign rsp_out_row   = rsp_head.row;
   assign rsp_out_c0    = rsp_head.chan[0];
   assign rsp_out_c1    = rsp_head.chan[1];
   assign rsp_out_c2    = rsp_head.chan[2];
   assign rsp_out_c3    = rsp_head.chan[3];
   assign rsp_area_done = rsp_head.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= 11'd640;
         cfg_height_ff <= 13'd480;
         cfg_chan_ff   <= 3'd4;
         cfg_ksize_ff  <= 3'd3;
         cfg_left_ff   <= '0;
         cfg_top_ff    <= '0;
         cfg_right_ff  <= 11'd640;
         cfg_bottom_ff <= 13'd480;
         restart_ff    <= 1'b1;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         ptr_x_ff      <= '0;
         ptr_y_ff      <= '0;
         busy_ff       <= 1'b0;
         outst_ff      <= '0;
         fetch_act_ff  <= 1'b0;
         prev_vld_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
         win_vld_ff    <= 1'b0;
         p_vld_ff      <= 1'b0;
         s_vld_ff      <= 1'b0;
         for (int i = 0; i < TAP_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         cfg_chan_ff   <= cfg_chan_in;
         cfg_ksize_ff  <= cfg_ksize_in;
         cfg_left_ff   <= cfg_left_in;
         cfg_top_ff    <= cfg_top_in;
         cfg_right_ff  <= cfg_right_in;
         cfg_bottom_ff <= cfg_bottom_in;
         restart_ff    <= restart_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         ptr_x_ff      <= ptr_x_in;
         ptr_y_ff      <= ptr_y_in;
         busy_ff       <= busy_in;
         outst_ff      <= outst_in;
         fetch_act_ff  <= fetch_act_in;
         prev_vld_ff   <= prev_vld_in;
         rd_vld_ff     <= iss;
         win_vld_ff    <= rd_vld_ff && rd_last_ff;
         p_vld_ff      <= win_vld_ff;
         s_vld_ff      <= p_vld_ff;
         if (req_acc && is_coef && (req_coef_index < 6'(TAP_COUNT))) begin
            coef_ff[req_coef_index] <= req_coef_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sx_ff       <= sx_in;
      cur_ff      <= cur_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      rd_last_ff  <= iss_last;
      rd_colok_ff <= iss_colok;
      rd_mask_ff  <= iss_mask;
      rd_base_ff  <= sy_base[2:0];
      rd_job_ff   <= iss_job;
      win_job_ff  <= rd_job_ff;
      p_job_ff    <= win_job_ff;
      s_job_ff    <= p_job_ff;
   end

endmodule

/* dv/ikc_checker.sv */
// Checker for the image kernel convolution unit: predicts every output pixel and compares it.
module ikc_checker import ikc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [7:0]         req_pix_c0,
   input  logic [7:0]         req_pix_c1,
   input  logic [7:0]         req_pix_c2,
   input  logic [7:0]         req_pix_c3,
   input  logic [5:0]         req_coef_index,
   input  logic signed [17:0] req_coef_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [9:0]         rsp_out_col,
   input  logic [11:0]        rsp_out_row,
   input  logic [7:0]         rsp_out_c0,
   input  logic [7:0]         rsp_out_c1,
   input  logic [7:0]         rsp_out_c2,
   input  logic [7:0]         rsp_out_c3,
   input  logic               rsp_area_done,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [12:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending_count,
   output int                 pixel_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [10:0] img_w;
   logic [12:0] img_h;
   logic [2:0]  chans;
   logic [2:0]  ksize;
   logic [10:0] a_left;
   logic [12:0] a_top;
   logic [10:0] a_right;
   logic [12:0] a_bottom;

   logic signed [17:0] coefs [TAP_COUNT];
   logic [31:0]        lines [ROW_SLOTS * IMG_W_MAX];
   int                 in_col, in_row, out_x, out_y;
   bit                 walking;
   rsp_type            expected_px [$];

   function automatic int width_used();
      if (img_w < 1) return 1;
      if (img_w > IMG_W_MAX) return IMG_W_MAX;
      return int'(img_w);
   endfunction

   function automatic int height_used();
      if (img_h < 1) return 1;
      if (img_h > IMG_H_MAX) return IMG_H_MAX;
      return int'(img_h);
   endfunction

   function automatic int right_used();
      return (int'(a_right) < width_used()) ? int'(a_right) : width_used();
   endfunction

   function automatic int bottom_used();
      return (int'(a_bottom) < height_used()) ? int'(a_bottom) : height_used();
   endfunction

   function automatic logic [7:0] clamp_byte(longint acc);
      longint t;
      t = acc + (longint'(1) << (FRAC_BITS - 1));
      if (t <= 0) return 8'd0;
      t = t >>> FRAC_BITS;
      if (t > 255) return 8'hff;
      return t[7:0];
   endfunction

   task automatic restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_x   = int'(a_left);
      out_y   = int'(a_top);
      walking = (int'(a_left) < right_used()) && (int'(a_top) < bottom_used());
   endtask

   task automatic predict_item();
      int w, h, k, half, hi, rr, cc, nch, sy, sx;
      longint acc [4];
      logic [31:0] px;
      rsp_type e;
      w = width_used();
      h = height_used();
      if (req_operation == OP_PIXEL) begin
         if (in_row >= h) restart_frame();
         if (in_col < w)
            lines[(in_row % ROW_SLOTS) * IMG_W_MAX + in_col] =
               {req_pix_c3, req_pix_c2, req_pix_c1, req_pix_c0};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end else if (req_operation == OP_COEF) begin
         if (req_coef_index < TAP_COUNT) coefs[req_coef_index] = req_coef_value;
      end
      if (!walking) return;
      k    = int'(ksize);
      half = k >> 1;
      hi   = (k > 0) ? k - 1 - half : 0;
      rr   = (out_y + hi < h - 1) ? out_y + hi : h - 1;
      cc   = (out_x + hi < w - 1) ? out_x + hi : w - 1;
      if (!(in_row > rr || (in_row == rr && in_col > cc))) return;
      nch = int'(chans);
      if (nch < 1) nch = 1;
      if (nch > 4) nch = 4;
      for (int c = 0; c < 4; c++) acc[c] = 0;
      for (int yy = 0; yy < k; yy++) begin
         sy = out_y + yy - half;
         if (sy < 0 || sy >= h) continue;
         for (int xx = 0; xx < k; xx++) begin
            sx = out_x + xx - half;
            if (sx < 0 || sx >= w) continue;
            px = lines[(sy % ROW_SLOTS) * IMG_W_MAX + sx];
            for (int c = 0; c < nch; c++)
               acc[c] += longint'(coefs[xx + yy * k]) * longint'(px[8 * c +: 8]);
         end
      end
      e.col = out_x[9:0];
      e.row = out_y[11:0];
      for (int c = 0; c < 4; c++) e.chan[c] = (c < nch) ? clamp_byte(acc[c]) : 8'd0;
      e.done = (out_x == right_used() - 1) && (out_y == bottom_used() - 1);
      expected_px.push_back(e);
      out_x++;
      if (out_x >= right_used()) begin
         out_x = int'(a_left);
         out_y++;
         if (out_y >= bottom_used()) walking = 0;
      end
   endtask

   task automatic check_output();
      rsp_type e, got;
      got.col  = rsp_out_col;
      got.row  = rsp_out_row;
      got.chan = {rsp_out_c3, rsp_out_c2, rsp_out_c1, rsp_out_c0};
      got.done = rsp_area_done;
      if (expected_px.size() == 0) begin
         if (fail_count < 10)
            $display("unexpected output pixel col %0d row %0d", got.col, got.row);
         fail_count++;
         return;
      end
      e = expected_px.pop_front();
      pixel_count++;
      if (got.col != e.col || got.row != e.row || got.chan != e.chan || got.done != e.done) begin
         if (fail_count < 10)
            $display("pixel differs: expected col %0d row %0d ch %h done %b, got col %0d row %0d ch %h done %b",
                     e.col, e.row, e.chan, e.done, got.col, got.row, got.chan, got.done);
         fail_count++;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      pixel_count   = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         img_w    = 11'd640;
         img_h    = 13'd480;
         chans    = 3'd4;
         ksize    = 3'd3;
         a_left   = '0;
         a_top    = '0;
         a_right  = 11'd640;
         a_bottom = 13'd480;
         for (int i = 0; i < TAP_COUNT; i++) coefs[i] = '0;
         expected_px.delete();
         restart_frame();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  img_w = csr_wdata[10:0];
                  restart_frame();
               end
               CSR_IMAGE_HEIGHT: begin
                  img_h = csr_wdata;
                  restart_frame();
               end
               CSR_CHANNEL_COUNT: begin
                  chans = csr_wdata[2:0];
                  restart_frame();
               end
               CSR_KERNEL_SIZE: begin
                  ksize = csr_wdata[2:0];
                  restart_frame();
               end
               CSR_AREA_LEFT: begin
                  a_left = csr_wdata[10:0];
                  restart_frame();
               end
               CSR_AREA_TOP: begin
                  a_top = csr_wdata;
                  restart_frame();
               end
               CSR_AREA_RIGHT: begin
                  a_right = csr_wdata[10:0];
                  restart_frame();
               end
               CSR_AREA_BOTTOM: begin
                  a_bottom = csr_wdata;
                  restart_frame();
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) predict_item();
         if (rsp_valid && rsp_ready) check_output();
      end
      pending_count <= expected_px.size();
   end

endmodule

/* dv/image_kernel_convolution_unit_tb.sv */
// Testbench top for the image kernel convolution unit: stimulus, flow control and verdict.
module image_kernel_convolution_unit_tb import ikc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_DRAIN = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 2000000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_operation = '0;
   logic [7:0]         req_pix_c0 = '0;
   logic [7:0]         req_pix_c1 = '0;
   logic [7:0]         req_pix_c2 = '0;
   logic [7:0]         req_pix_c3 = '0;
   logic [5:0]         req_coef_index = '0;
   logic signed [17:0] req_coef_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [9:0]         rsp_out_col;
   logic [11:0]        rsp_out_row;
   logic [7:0]         rsp_out_c0, rsp_out_c1, rsp_out_c2, rsp_out_c3;
   logic               rsp_area_done;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [12:0]        csr_wdata = '0;

   int fail_count, pending_count, pixel_count;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_len = 0;
   int hold_left = 0;
   int items_sent = 0;
   int frames_run = 0;
   int cycles = 0;

   image_kernel_convolution_unit DUT (.*);

   ikc_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("image_kernel_convolution_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(logic [1:0] op, logic [31:0] px, logic [5:0] idx,
                            logic signed [17:0] val);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_pix_c0     <= px[7:0];
      req_pix_c1     <= px[15:8];
      req_pix_c2     <= px[23:16];
      req_pix_c3     <= px[31:24];
      req_coef_index <= idx;
      req_coef_value <= val;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_pixel(logic [31:0] px);
      send_item(OP_PIXEL, px, 6'($urandom), 18'($urandom));
   endtask

   task automatic send_drain();
      send_item(($urandom_range(7) == 0) ? OP_SPARE : OP_DRAIN, $urandom,
                6'($urandom), 18'($urandom));
   endtask

   task automatic send_coef(int idx, int val);
      send_item(OP_COEF, $urandom, 6'(idx), 18'(val));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] idx, int data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 13'(data);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_frame(int w, int h, int ch, int k, int l, int t, int r, int b);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_CHANNEL_COUNT, ch);
      write_reg(CSR_KERNEL_SIZE, k);
      write_reg(CSR_AREA_LEFT, l);
      write_reg(CSR_AREA_TOP, t);
      write_reg(CSR_AREA_RIGHT, r);
      write_reg(CSR_AREA_BOTTOM, b);
   endtask

   task automatic load_kernel();
      for (int i = 0; i < TAP_COUNT; i++) begin
         case ($urandom_range(9))
            0: send_coef(i, -131072);
            1: send_coef(i, 131071);
            2: send_coef(i, 0);
            default: send_coef(i, $urandom_range(1600) - 500);
         endcase
      end
   endtask

   // Streams pixel_total pixels with some noise, then the given number of drain items.
   task automatic stream_frame(int pixel_total, int drains);
      for (int i = 0; i < pixel_total; i++) begin
         send_pixel($urandom);
         if ($urandom_range(19) == 0) send_drain();
         if ($urandom_range(99) == 0) send_coef($urandom_range(63), $urandom_range(1600) - 500);
      end
      repeat (drains) send_drain();
      frames_run++;
   endtask

   task automatic random_frame();
      int w, h, l, t, r, b;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      l = $urandom_range(0, w - 1);
      t = $urandom_range(0, h - 1);
      r = $urandom_range(l + 1, w + 2);
      b = $urandom_range(t + 1, h + 2);
      if ($urandom_range(15) == 0) r = l;
      if ($urandom_range(3) != 0)
         set_frame(w, h, $urandom_range(7), $urandom_range(7), l, t, r, b);
      if ($urandom_range(4) == 0) load_kernel();
      if ($urandom_range(7) == 0)
         stream_frame($urandom_range(0, w * h), w * h + 4);
      else
         stream_frame(w * h, w * h + 4);
   endtask

   task automatic directed_part();
      set_frame(3, 3, 4, 3, 0, 0, 3, 3);
      send_coef(4, 4096);
      send_coef(63, 131071);
      send_coef(49, -131072);
      send_pixel(32'hffffffff);
      send_pixel(32'h00000000);
      send_pixel(32'h00ff00ff);
      send_pixel(32'hff00ff00);
      send_pixel(32'h80402010);
      send_pixel(32'h01020304);
      send_pixel(32'hfffefdfc);
      send_pixel(32'h7f7f7f7f);
      send_pixel(32'hffffffff);
      repeat (8) send_drain();
      send_coef(0, 131071);
      send_coef(1, -131072);
      set_frame(2, 2, 2, 0, 0, 0, 2, 2);
      repeat (4) send_pixel($urandom);
      repeat (4) send_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct = 29;
      rsp_idle_pct = 54;
      directed_part();
      set_frame(5, 4, 3, 7, 1024, 8191, 0, 0);
      stream_frame(20, 4);
      write_reg(4'd9, 13'h1fff);
      write_reg(4'd15, 0);
      load_kernel();
      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 54 : 0;
         rsp_idle_pct = (mode == 0) ? 54 : (mode == 1) ? 29 : 0;
         if (mode == 2) begin
            set_frame(12, 10, 4, 3, 0, 0, 12, 10);
            hold_len = 400;
            stream_frame(120, 124);
            wait_drained();
         end
         while (items_sent < 450 * (mode + 1)) random_frame();
      end
      set_frame(2047, 1, 4, 7, 0, 0, 2047, 8191);
      stream_frame(60, 8);
      set_frame(0, 8191, 1, 5, 0, 0, 1, 8191);
      stream_frame(60, 10);
      set_frame(1024, 1, 2, 1, 0, 0, 4, 1);
      stream_frame(40, 8);
      wait_drained();
      $display("%0d items over %0d frames, %0d output pixels compared",
               items_sent, frames_run, pixel_count);
      $display("covered kernel sizes 0..7, channel counts 0..7, empty and clipped areas");
      if (fail_count == 0) begin
         $display("image_kernel_convolution_unit: match");
      end else begin
         $display("image_kernel_convolution_unit: mismatch");
      end
      $finish;
   end

endmodule
